// ===== design/d2q9_pkg.sv =====
// Shared types, fixed-point constants and saturating arithmetic for the
// D2Q9 BGK collision pipeline. No dependencies.
`default_nettype none

package d2q9_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 24;
    localparam int DENS_W      = 31;
    localparam int RATE_W      = 26;
    localparam int NUM_DIR     = 9;
    localparam int PIPE_STAGES = 8;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int QUO_W       = PROD_W - FRAC_BITS;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [RATE_W-1:0]        rate_t;
    typedef logic [DENS_W-1:0]        dens_t;
    typedef word_t                    dir_arr_t [NUM_DIR];

    // Direction indices, in the order of the distribution ports.
    localparam int DIR_REST       = 0;
    localparam int DIR_EAST       = 1;
    localparam int DIR_NORTH      = 2;
    localparam int DIR_WEST       = 3;
    localparam int DIR_SOUTH      = 4;
    localparam int DIR_NORTHEAST  = 5;
    localparam int DIR_NORTHWEST  = 6;
    localparam int DIR_SOUTHWEST  = 7;
    localparam int DIR_SOUTHEAST  = 8;
    localparam int DIR_FIRST_DIAG = DIR_NORTHEAST;

    localparam word_t WMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam longint ONE_L = 64'sd1 << FRAC_BITS;

    localparam word_t C_ONE       = word_t'(ONE_L);
    localparam word_t C_HALF      = word_t'(ONE_L / 2);
    localparam word_t C_THREE     = word_t'(3 * ONE_L);
    localparam word_t C_THREEHALF = word_t'((3 * ONE_L) / 2);

    // Lattice weights 4/9, 1/9 and 1/36, rounded to nearest.
    localparam word_t W_REST = word_t'((4 * ONE_L * 2 + 9) / 18);
    localparam word_t W_AXIS = word_t'((ONE_L * 2 + 9) / 18);
    localparam word_t W_DIAG = word_t'((ONE_L * 2 + 36) / 72);

    localparam rate_t RELAX_RESET = rate_t'(ONE_L);

    function automatic word_t sadd(input word_t a, input word_t b);
        logic [DATA_W:0] sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            return sum[DATA_W] ? WMIN : WMAX;
        end
        return word_t'(sum[DATA_W-1:0]);
    endfunction

    function automatic word_t sneg(input word_t a);
        return (a == WMIN) ? WMAX : word_t'(-a);
    endfunction

    // Subtraction goes through negation, so subtracting the most negative
    // value adds the most positive one.
    function automatic word_t ssub(input word_t a, input word_t b);
        return sadd(a, sneg(b));
    endfunction

    // Full product, arithmetic shift (floor), then clamp to the word range.
    function automatic word_t smul(input word_t a, input word_t b);
        logic signed [PROD_W-1:0] prod;
        logic [QUO_W-1:0]         quo;
        prod = PROD_W'(a) * PROD_W'(b);
        quo  = prod[PROD_W-1:FRAC_BITS];
        if (!quo[QUO_W-1] && (|quo[QUO_W-2:DATA_W-1])) begin
            return WMAX;
        end
        if (quo[QUO_W-1] && !(&quo[QUO_W-2:DATA_W-1])) begin
            return WMIN;
        end
        return word_t'(quo[DATA_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== design/d2q9_pipe_ctrl.sv =====
// Valid and ready control for the collision pipeline: one valid bit per
// stage, bubbles collapse, and each stage loads only when it can move.
// Depends on d2q9_pkg.
`default_nettype none

module d2q9_pipe_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [d2q9_pkg::PIPE_STAGES-1:0]   stage_load
);
    import d2q9_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   stage_rdy;
    logic [PIPE_STAGES-1:0] upstream_valid;

    assign upstream_valid = {valid_reg[PIPE_STAGES-2:0], s_valid};

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        stage_rdy[PIPE_STAGES] = m_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            valid_next[k] = stage_rdy[k] ? upstream_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_load = stage_rdy[PIPE_STAGES-1:0];
    assign s_ready    = stage_rdy[0];
    assign m_valid    = valid_reg[PIPE_STAGES-1];

`ifndef ASSERT_OFF
    // Items in flight change only by the transactions on the two channels.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            $countones(valid_reg) == $past($countones(valid_reg))
                + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready)))
        else $error("pipeline occupancy does not match transactions");

    a_empty_front_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("empty first stage refused an input transaction");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg && !m_ready) |-> !s_ready)
        else $error("full stalled pipeline accepted an input transaction");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted input transaction lost at first stage");
`endif

endmodule

`default_nettype wire

// ===== design/d2q9_datapath.sv =====
// Eight-stage fixed-point datapath of the BGK collision: weights and
// velocity products, direction terms, polynomial, relaxation and final sum.
// Depends on d2q9_pkg.
`default_nettype none

module d2q9_datapath (
    input  logic                             aclk,
    input  logic [d2q9_pkg::PIPE_STAGES-1:0] stage_load,
    input  d2q9_pkg::word_t                  omega,
    input  d2q9_pkg::word_t                  omp,
    input  d2q9_pkg::dens_t                  rho,
    input  d2q9_pkg::word_t                  vel_x,
    input  d2q9_pkg::word_t                  vel_y,
    input  d2q9_pkg::dir_arr_t               f_in,
    output d2q9_pkg::dir_arr_t               f_out
);
    import d2q9_pkg::*;

    // Stage 0: products of the raw inputs.
    word_t s0_ow_rest_reg, s0_ow_axis_reg, s0_ow_diag_reg;
    word_t s0_rho_reg, s0_uxx_reg, s0_uyy_reg, s0_tux_reg, s0_tuy_reg;
    word_t s0_pf_reg [NUM_DIR];
    // Stage 1: weighted densities, speed squared, direction projections.
    word_t s1_tw_rest_reg, s1_tw_axis_reg, s1_tw_diag_reg, s1_usq_reg;
    word_t s1_e_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s1_pf_reg [NUM_DIR];
    // Stage 2.
    word_t s2_tw_rest_reg, s2_tw_axis_reg, s2_tw_diag_reg, s2_usq3_reg;
    word_t s2_e_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s2_he_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s2_pf_reg [NUM_DIR];
    // Stage 3.
    word_t s3_tw_rest_reg, s3_tw_axis_reg, s3_tw_diag_reg, s3_omusq_reg;
    word_t s3_e_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s3_a_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s3_pf_reg [NUM_DIR];
    // Stage 4.
    word_t s4_tw_rest_reg, s4_tw_axis_reg, s4_tw_diag_reg, s4_omusq_reg;
    word_t s4_pe_reg [DIR_EAST:DIR_SOUTHEAST];
    word_t s4_pf_reg [NUM_DIR];
    // Stage 5.
    word_t s5_tw_rest_reg, s5_tw_axis_reg, s5_tw_diag_reg;
    word_t s5_poly_reg [NUM_DIR];
    word_t s5_pf_reg [NUM_DIR];
    // Stage 6.
    word_t s6_pt_reg [NUM_DIR];
    word_t s6_pf_reg [NUM_DIR];
    // Stage 7: result.
    word_t s7_r_reg [NUM_DIR];

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            s0_ow_rest_reg <= smul(omega, W_REST);
            s0_ow_axis_reg <= smul(omega, W_AXIS);
            s0_ow_diag_reg <= smul(omega, W_DIAG);
            s0_rho_reg     <= word_t'({{(DATA_W-DENS_W){1'b0}}, rho});
            s0_uxx_reg     <= smul(vel_x, vel_x);
            s0_uyy_reg     <= smul(vel_y, vel_y);
            s0_tux_reg     <= smul(C_THREE, vel_x);
            s0_tuy_reg     <= smul(C_THREE, vel_y);
            for (int i = 0; i < NUM_DIR; i++) begin
                s0_pf_reg[i] <= smul(omp, f_in[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[1]) begin
            s1_tw_rest_reg <= smul(s0_ow_rest_reg, s0_rho_reg);
            s1_tw_axis_reg <= smul(s0_ow_axis_reg, s0_rho_reg);
            s1_tw_diag_reg <= smul(s0_ow_diag_reg, s0_rho_reg);
            s1_usq_reg     <= sadd(s0_uxx_reg, s0_uyy_reg);
            s1_e_reg[DIR_EAST]      <= s0_tux_reg;
            s1_e_reg[DIR_NORTH]     <= s0_tuy_reg;
            s1_e_reg[DIR_WEST]      <= sneg(s0_tux_reg);
            s1_e_reg[DIR_SOUTH]     <= sneg(s0_tuy_reg);
            s1_e_reg[DIR_NORTHEAST] <= sadd(s0_tux_reg, s0_tuy_reg);
            s1_e_reg[DIR_NORTHWEST] <= ssub(s0_tuy_reg, s0_tux_reg);
            s1_e_reg[DIR_SOUTHWEST] <= ssub(sneg(s0_tux_reg), s0_tuy_reg);
            s1_e_reg[DIR_SOUTHEAST] <= ssub(s0_tux_reg, s0_tuy_reg);
            s1_pf_reg <= s0_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[2]) begin
            s2_tw_rest_reg <= s1_tw_rest_reg;
            s2_tw_axis_reg <= s1_tw_axis_reg;
            s2_tw_diag_reg <= s1_tw_diag_reg;
            s2_usq3_reg    <= smul(C_THREEHALF, s1_usq_reg);
            for (int i = DIR_EAST; i <= DIR_SOUTHEAST; i++) begin
                s2_he_reg[i] <= smul(C_HALF, s1_e_reg[i]);
            end
            s2_e_reg  <= s1_e_reg;
            s2_pf_reg <= s1_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[3]) begin
            s3_tw_rest_reg <= s2_tw_rest_reg;
            s3_tw_axis_reg <= s2_tw_axis_reg;
            s3_tw_diag_reg <= s2_tw_diag_reg;
            s3_omusq_reg   <= ssub(C_ONE, s2_usq3_reg);
            for (int i = DIR_EAST; i <= DIR_SOUTHEAST; i++) begin
                s3_a_reg[i] <= sadd(C_ONE, s2_he_reg[i]);
            end
            s3_e_reg  <= s2_e_reg;
            s3_pf_reg <= s2_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[4]) begin
            s4_tw_rest_reg <= s3_tw_rest_reg;
            s4_tw_axis_reg <= s3_tw_axis_reg;
            s4_tw_diag_reg <= s3_tw_diag_reg;
            s4_omusq_reg   <= s3_omusq_reg;
            for (int i = DIR_EAST; i <= DIR_SOUTHEAST; i++) begin
                s4_pe_reg[i] <= smul(s3_e_reg[i], s3_a_reg[i]);
            end
            s4_pf_reg <= s3_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[5]) begin
            s5_tw_rest_reg <= s4_tw_rest_reg;
            s5_tw_axis_reg <= s4_tw_axis_reg;
            s5_tw_diag_reg <= s4_tw_diag_reg;
            // The rest direction has no velocity term.
            s5_poly_reg[DIR_REST] <= s4_omusq_reg;
            for (int i = DIR_EAST; i <= DIR_SOUTHEAST; i++) begin
                s5_poly_reg[i] <= sadd(s4_omusq_reg, s4_pe_reg[i]);
            end
            s5_pf_reg <= s4_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[6]) begin
            s6_pt_reg[DIR_REST] <= smul(s5_tw_rest_reg, s5_poly_reg[DIR_REST]);
            for (int i = DIR_EAST; i <= DIR_SOUTHEAST; i++) begin
                s6_pt_reg[i] <= smul((i < DIR_FIRST_DIAG) ? s5_tw_axis_reg
                                                          : s5_tw_diag_reg,
                                     s5_poly_reg[i]);
            end
            s6_pf_reg <= s5_pf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[7]) begin
            for (int i = 0; i < NUM_DIR; i++) begin
                s7_r_reg[i] <= sadd(s6_pf_reg[i], s6_pt_reg[i]);
            end
        end
    end

    assign f_out = s7_r_reg;

endmodule

`default_nettype wire

// ===== design/d2q9_bgk_collision.sv =====
// Top level of the D2Q9 BGK collision block: relaxation-rate register,
// pipeline control and datapath. Depends on d2q9_pkg, d2q9_pipe_ctrl and
// d2q9_datapath.
//
// Each input transaction carries one lattice node (density in unsigned
// Q7.24, velocity and nine distributions in signed Q8.24) and yields one
// output transaction with the nine relaxed distributions, saturated to the
// Q8.24 range. The block takes one node per clock unless the output stalls;
// each node passes the eight register stages of the multiply/add pipeline.
// Stalls on the output back up stage by stage, and empty stages keep
// filling, so a waiting result does not stop input while there is room.
// The relaxation rate omega (unsigned Q2.24, reset 1.0) is set through the
// cfg port (always ready); write it only while no node is in flight.
`default_nettype none

module d2q9_bgk_collision (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  d2q9_pkg::rate_t       cfg_relax_rate,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  d2q9_pkg::dens_t       s_density,
    input  d2q9_pkg::word_t       s_vel_x,
    input  d2q9_pkg::word_t       s_vel_y,
    input  d2q9_pkg::word_t       s_f_rest_in,
    input  d2q9_pkg::word_t       s_f_east_in,
    input  d2q9_pkg::word_t       s_f_north_in,
    input  d2q9_pkg::word_t       s_f_west_in,
    input  d2q9_pkg::word_t       s_f_south_in,
    input  d2q9_pkg::word_t       s_f_northeast_in,
    input  d2q9_pkg::word_t       s_f_northwest_in,
    input  d2q9_pkg::word_t       s_f_southwest_in,
    input  d2q9_pkg::word_t       s_f_southeast_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output d2q9_pkg::word_t       m_f_rest_out,
    output d2q9_pkg::word_t       m_f_east_out,
    output d2q9_pkg::word_t       m_f_north_out,
    output d2q9_pkg::word_t       m_f_west_out,
    output d2q9_pkg::word_t       m_f_south_out,
    output d2q9_pkg::word_t       m_f_northeast_out,
    output d2q9_pkg::word_t       m_f_northwest_out,
    output d2q9_pkg::word_t       m_f_southwest_out,
    output d2q9_pkg::word_t       m_f_southeast_out
);
    import d2q9_pkg::*;

    rate_t    relax_rate_reg;
    word_t    omp_reg;
    word_t    omp_next;
    word_t    omega;
    word_t    cfg_omega;
    dir_arr_t f_in;
    dir_arr_t f_out;
    logic [PIPE_STAGES-1:0] stage_load;

    assign cfg_ready = 1'b1;
    assign omega     = word_t'({{(DATA_W-RATE_W){1'b0}}, relax_rate_reg});
    assign cfg_omega = word_t'({{(DATA_W-RATE_W){1'b0}}, cfg_relax_rate});
    // 1 - omega is kept with the rate so the first stage only multiplies.
    assign omp_next  = ssub(C_ONE, cfg_omega);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_rate_reg <= RELAX_RESET;
            omp_reg        <= ssub(C_ONE, word_t'({{(DATA_W-RATE_W){1'b0}}, RELAX_RESET}));
        end else if (cfg_valid && cfg_ready) begin
            relax_rate_reg <= cfg_relax_rate;
            omp_reg        <= omp_next;
        end
    end

    assign f_in[DIR_REST]      = s_f_rest_in;
    assign f_in[DIR_EAST]      = s_f_east_in;
    assign f_in[DIR_NORTH]     = s_f_north_in;
    assign f_in[DIR_WEST]      = s_f_west_in;
    assign f_in[DIR_SOUTH]     = s_f_south_in;
    assign f_in[DIR_NORTHEAST] = s_f_northeast_in;
    assign f_in[DIR_NORTHWEST] = s_f_northwest_in;
    assign f_in[DIR_SOUTHWEST] = s_f_southwest_in;
    assign f_in[DIR_SOUTHEAST] = s_f_southeast_in;

    d2q9_pipe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stage_load (stage_load)
    );

    d2q9_datapath u_datapath (
        .aclk       (aclk),
        .stage_load (stage_load),
        .omega      (omega),
        .omp        (omp_reg),
        .rho        (s_density),
        .vel_x      (s_vel_x),
        .vel_y      (s_vel_y),
        .f_in       (f_in),
        .f_out      (f_out)
    );

    assign m_f_rest_out      = f_out[DIR_REST];
    assign m_f_east_out      = f_out[DIR_EAST];
    assign m_f_north_out     = f_out[DIR_NORTH];
    assign m_f_west_out      = f_out[DIR_WEST];
    assign m_f_south_out     = f_out[DIR_SOUTH];
    assign m_f_northeast_out = f_out[DIR_NORTHEAST];
    assign m_f_northwest_out = f_out[DIR_NORTHWEST];
    assign m_f_southwest_out = f_out[DIR_SOUTHWEST];
    assign m_f_southeast_out = f_out[DIR_SOUTHEAST];

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the D2Q9 BGK collision block: random lattice nodes
// against a saturating Q8.24 predictor. Depends on d2q9_pkg and d2q9_bgk_collision.

module tb;

    import d2q9_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    localparam longint UNIT     = longint'(1) << FRAC_BITS;
    localparam longint WORD_MAX = (longint'(1) << (DATA_W - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    localparam word_t K_ONE       = word_t'(UNIT);
    localparam word_t K_HALF      = word_t'(UNIT / 2);
    localparam word_t K_THREE     = word_t'(3 * UNIT);
    localparam word_t K_THREEHALF = word_t'((3 * UNIT) / 2);
    localparam word_t K_WREST     = word_t'((8 * UNIT + 9) / 18);
    localparam word_t K_WAXIS     = word_t'((2 * UNIT + 9) / 18);
    localparam word_t K_WDIAG     = word_t'((2 * UNIT + 36) / 72);
    localparam word_t K_WMAX      = word_t'(WORD_MAX);
    localparam word_t K_WMIN      = word_t'(WORD_MIN);

    typedef logic [NUM_DIR-1:0][DATA_W-1:0] dirs_t;

    typedef struct packed {
        dens_t density;
        word_t vel_x;
        word_t vel_y;
        dirs_t f;
    } node_t;

    logic  aclk;
    logic  aresetn;
    logic  cfg_valid;
    logic  cfg_ready;
    rate_t cfg_relax_rate;
    logic  s_valid;
    logic  s_ready;
    dens_t s_density;
    word_t s_vel_x, s_vel_y;
    word_t s_f_rest_in, s_f_east_in, s_f_north_in, s_f_west_in, s_f_south_in;
    word_t s_f_northeast_in, s_f_northwest_in, s_f_southwest_in, s_f_southeast_in;
    logic  m_valid;
    logic  m_ready;
    word_t m_f_rest_out, m_f_east_out, m_f_north_out, m_f_west_out, m_f_south_out;
    word_t m_f_northeast_out, m_f_northwest_out, m_f_southwest_out, m_f_southeast_out;

    rate_t relax_model;
    dirs_t relaxed_q [$];
    int    mismatches;
    int    results_seen;
    int    idle_cycles;
    int    src_run;
    int    snk_run;
    bit    no_idle;
    dirs_t want_dirs;
    dirs_t got_dirs;

    d2q9_bgk_collision dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_relax_rate    (cfg_relax_rate),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_density         (s_density),
        .s_vel_x           (s_vel_x),
        .s_vel_y           (s_vel_y),
        .s_f_rest_in       (s_f_rest_in),
        .s_f_east_in       (s_f_east_in),
        .s_f_north_in      (s_f_north_in),
        .s_f_west_in       (s_f_west_in),
        .s_f_south_in      (s_f_south_in),
        .s_f_northeast_in  (s_f_northeast_in),
        .s_f_northwest_in  (s_f_northwest_in),
        .s_f_southwest_in  (s_f_southwest_in),
        .s_f_southeast_in  (s_f_southeast_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_f_rest_out      (m_f_rest_out),
        .m_f_east_out      (m_f_east_out),
        .m_f_north_out     (m_f_north_out),
        .m_f_west_out      (m_f_west_out),
        .m_f_south_out     (m_f_south_out),
        .m_f_northeast_out (m_f_northeast_out),
        .m_f_northwest_out (m_f_northwest_out),
        .m_f_southwest_out (m_f_southwest_out),
        .m_f_southeast_out (m_f_southeast_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Saturating Q8.24 arithmetic used by the collision predictor.
    function automatic word_t clamp_word(input longint v);
        if (v > WORD_MAX) return K_WMAX;
        if (v < WORD_MIN) return K_WMIN;
        return word_t'(v);
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        return clamp_word(longint'(a) + longint'(b));
    endfunction

    function automatic word_t sat_neg(input word_t a);
        return (a == K_WMIN) ? K_WMAX : word_t'(-a);
    endfunction

    // Negating first means that subtracting the most negative value adds the
    // most positive one, one short of the true difference.
    function automatic word_t sat_sub(input word_t a, input word_t b);
        return sat_add(a, sat_neg(b));
    endfunction

    // The product of two words fits in 63 bits, so an arithmetic shift gives
    // the floor of the scaled product directly.
    function automatic word_t fx_mul(input word_t a, input word_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp_word(prod >>> FRAC_BITS);
    endfunction

    function automatic word_t dir_weight(input int d);
        if (d == DIR_REST) return K_WREST;
        return (d < DIR_FIRST_DIAG) ? K_WAXIS : K_WDIAG;
    endfunction

    function automatic string dir_label(input int d);
        case (d)
            DIR_REST:      return "rest";
            DIR_EAST:      return "east";
            DIR_NORTH:     return "north";
            DIR_WEST:      return "west";
            DIR_SOUTH:     return "south";
            DIR_NORTHEAST: return "northeast";
            DIR_NORTHWEST: return "northwest";
            DIR_SOUTHWEST: return "southwest";
            default:       return "southeast";
        endcase
    endfunction

    function automatic dirs_t relax_node(input node_t n, input rate_t rate);
        word_t omega, omp, rho, omusq, tux, tuy, tw, poly;
        word_t proj [NUM_DIR];
        dirs_t r;
        omega = word_t'(longint'(rate));
        omp   = sat_sub(K_ONE, omega);
        rho   = word_t'({1'b0, n.density});
        omusq = sat_sub(K_ONE, fx_mul(K_THREEHALF,
                        sat_add(fx_mul(n.vel_x, n.vel_x), fx_mul(n.vel_y, n.vel_y))));
        tux = fx_mul(K_THREE, n.vel_x);
        tuy = fx_mul(K_THREE, n.vel_y);
        proj[DIR_REST]      = '0;
        proj[DIR_EAST]      = tux;
        proj[DIR_NORTH]     = tuy;
        proj[DIR_WEST]      = sat_neg(tux);
        proj[DIR_SOUTH]     = sat_neg(tuy);
        proj[DIR_NORTHEAST] = sat_add(tux, tuy);
        proj[DIR_NORTHWEST] = sat_sub(tuy, tux);
        proj[DIR_SOUTHWEST] = sat_sub(sat_neg(tux), tuy);
        proj[DIR_SOUTHEAST] = sat_sub(tux, tuy);
        tw = fx_mul(fx_mul(omega, K_WREST), rho);
        r[DIR_REST] = sat_add(fx_mul(omp, n.f[DIR_REST]), fx_mul(tw, omusq));
        for (int d = DIR_EAST; d < NUM_DIR; d++) begin
            tw   = fx_mul(fx_mul(omega, dir_weight(d)), rho);
            poly = sat_add(omusq, fx_mul(proj[d],
                           sat_add(K_ONE, fx_mul(K_HALF, proj[d]))));
            r[d] = sat_add(fx_mul(omp, n.f[d]), fx_mul(tw, poly));
        end
        return r;
    endfunction

    function automatic node_t make_node(input dens_t dens, input word_t vx, input word_t vy,
                                        input word_t fr, input word_t fa, input word_t fd);
        node_t n;
        n.density = dens;
        n.vel_x   = vx;
        n.vel_y   = vy;
        for (int d = 0; d < NUM_DIR; d++) begin
            n.f[d] = (d == DIR_REST) ? fr : ((d < DIR_FIRST_DIAG) ? fa : fd);
        end
        return n;
    endfunction

    function automatic word_t pick_edge();
        case ($urandom_range(0, 5))
            0:       return K_WMIN;
            1:       return K_WMAX;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly near-equilibrium nodes, plus full-range noise and saturating cases.
    function automatic node_t rand_node();
        node_t  n;
        longint rho;
        n = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                rho = UNIT + longint'($urandom_range(0, UNIT / 2)) - UNIT / 4;
                n.density = dens_t'(rho);
                n.vel_x = word_t'(longint'($urandom_range(0, 10066330)) - 5033165);
                n.vel_y = word_t'(longint'($urandom_range(0, 10066330)) - 5033165);
                for (int d = 0; d < NUM_DIR; d++) begin
                    n.f[d] = word_t'(((rho * longint'(dir_weight(d))) >>> FRAC_BITS)
                                     + longint'($urandom_range(0, 1 << 19)) - (1 << 18));
                end
            end
            6, 7: begin
                n.density = dens_t'($urandom);
                n.vel_x = $urandom;
                n.vel_y = $urandom;
                for (int d = 0; d < NUM_DIR; d++) n.f[d] = $urandom;
            end
            8: begin
                case ($urandom_range(0, 3))
                    0:       n.density = '0;
                    1:       n.density = '1;
                    2:       n.density = dens_t'(1);
                    default: n.density = dens_t'($urandom);
                endcase
                n.vel_x = pick_edge();
                n.vel_y = pick_edge();
                for (int d = 0; d < NUM_DIR; d++) n.f[d] = pick_edge();
            end
            default: begin
                n.density = dens_t'($urandom_range(0, 16 * UNIT));
                n.vel_x = word_t'(longint'($urandom_range(0, 4 * UNIT)) - 2 * UNIT);
                n.vel_y = word_t'(longint'($urandom_range(0, 4 * UNIT)) - 2 * UNIT);
                for (int d = 0; d < NUM_DIR; d++) begin
                    n.f[d] = word_t'(longint'($urandom_range(0, 16 * UNIT)) - 8 * UNIT);
                end
            end
        endcase
        return n;
    endfunction

    // Wait before the next transaction; now and then a run of back-to-back ones.
    task automatic draw_wait(inout int run_left, output int cycles);
        cycles = 0;
        if (no_idle) begin
            cycles = 0;
        end else if (run_left > 0) begin
            run_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(16, 48);
        end else begin
            cycles = $urandom_range(0, 19);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_node(input node_t n);
        int gap;
        draw_wait(src_run, gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_density        <= n.density;
        s_vel_x          <= n.vel_x;
        s_vel_y          <= n.vel_y;
        s_f_rest_in      <= n.f[DIR_REST];
        s_f_east_in      <= n.f[DIR_EAST];
        s_f_north_in     <= n.f[DIR_NORTH];
        s_f_west_in      <= n.f[DIR_WEST];
        s_f_south_in     <= n.f[DIR_SOUTH];
        s_f_northeast_in <= n.f[DIR_NORTHEAST];
        s_f_northwest_in <= n.f[DIR_NORTHWEST];
        s_f_southwest_in <= n.f[DIR_SOUTHWEST];
        s_f_southeast_in <= n.f[DIR_SOUTHEAST];
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        relaxed_q.push_back(relax_node(n, relax_model));
    endtask

    // Holds the input idle until every pending node has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (relaxed_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_relax_rate(input rate_t rate);
        cfg_relax_rate <= rate;
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        relax_model = rate;
    endtask

    task automatic test_reset_rate();
        send_node(make_node('0, '0, '0, '0, '0, '0));
        send_node(make_node(dens_t'(UNIT), '0, '0, K_WREST, K_WAXIS, K_WDIAG));
        send_node(make_node(dens_t'(UNIT), 1677722, -838861, K_WREST, K_WAXIS, K_WDIAG));
        send_node(make_node('1, K_WMAX, K_WMAX, K_WMAX, K_WMAX, K_WMAX));
        send_node(make_node('0, K_WMIN, K_WMIN, K_WMIN, K_WMIN, K_WMIN));
        send_node(make_node('1, K_WMIN, K_WMAX, K_WMIN, K_WMAX, -1));
        send_node(make_node(31'h2AAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                            32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA));
        send_node(make_node(31'h55555555, 32'h55555555, 32'h55555555,
                            32'h55555555, 32'h55555555, 32'h55555555));
        // Negative distributions at a physical velocity.
        send_node(make_node(dens_t'(2 * UNIT), 5033165, 5033165,
                            word_t'(-UNIT / 2), word_t'(-UNIT / 2), word_t'(-UNIT / 2)));
        // Velocities far outside the physical range saturate u.u.
        send_node(make_node(dens_t'(UNIT), word_t'(40 * UNIT), word_t'(-40 * UNIT),
                            K_WREST, K_WAXIS, K_WDIAG));
        // Tiny negative values exercise rounding toward minus infinity.
        send_node(make_node(dens_t'(UNIT), -1, -3, -1, -1, -1));
        drain_results();
    endtask

    task automatic test_rate_extremes();
        rate_t rate;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0:       rate = '0;
                1:       rate = rate_t'(2 * UNIT);
                2:       rate = '1;
                default: rate = rate_t'(1);
            endcase
            write_relax_rate(rate);
            send_node(make_node(dens_t'(UNIT), 1677722, -838861, K_WREST, K_WAXIS, K_WDIAG));
            send_node(make_node('1, K_WMAX, K_WMIN, K_WMAX, K_WMIN, K_WMAX));
            send_node(rand_node());
            drain_results();
        end
    endtask

    task automatic test_random_nodes();
        rate_t rate;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       rate = rate_t'($urandom_range(0, 2 * UNIT));
                1:       rate = rate_t'($urandom);
                2:       rate = '1;
                3:       rate = '0;
                4:       rate = rate_t'(UNIT);
                5:       rate = rate_t'(2 * UNIT);
                default: rate = rate_t'($urandom_range(0, 2 * UNIT));
            endcase
            write_relax_rate(rate);
            for (int i = 0; i < 110; i++) begin
                if (phase == 2 && i == 55) drain_results();
                send_node(rand_node());
            end
            drain_results();
        end
    endtask

    task automatic test_back_to_back();
        write_relax_rate(rate_t'($urandom_range(UNIT / 2, 2 * UNIT)));
        no_idle = 1'b1;
        for (int i = 0; i < 80; i++) send_node(rand_node());
        drain_results();
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_relax_rate   <= '0;
        s_valid          <= 1'b0;
        s_density        <= '0;
        s_vel_x          <= '0;
        s_vel_y          <= '0;
        s_f_rest_in      <= '0;
        s_f_east_in      <= '0;
        s_f_north_in     <= '0;
        s_f_west_in      <= '0;
        s_f_south_in     <= '0;
        s_f_northeast_in <= '0;
        s_f_northwest_in <= '0;
        s_f_southwest_in <= '0;
        s_f_southeast_in <= '0;
        relax_model  = rate_t'(UNIT);
        mismatches   = 0;
        results_seen = 0;
        src_run      = 0;
        snk_run      = 0;
        no_idle      = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_rate();
        test_rate_extremes();
        test_random_nodes();
        test_back_to_back();
        drain_results();
        repeat (PIPE_STAGES + 4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random back-pressure before each transaction.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            draw_wait(snk_run, stall);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_dirs[DIR_REST]      = m_f_rest_out;
            got_dirs[DIR_EAST]      = m_f_east_out;
            got_dirs[DIR_NORTH]     = m_f_north_out;
            got_dirs[DIR_WEST]      = m_f_west_out;
            got_dirs[DIR_SOUTH]     = m_f_south_out;
            got_dirs[DIR_NORTHEAST] = m_f_northeast_out;
            got_dirs[DIR_NORTHWEST] = m_f_northwest_out;
            got_dirs[DIR_SOUTHWEST] = m_f_southwest_out;
            got_dirs[DIR_SOUTHEAST] = m_f_southeast_out;
            if (relaxed_q.size() == 0) begin
                report_mismatch("result transaction with no node pending");
            end else begin
                want_dirs = relaxed_q.pop_front();
                for (int d = 0; d < NUM_DIR; d++) begin
                    if (got_dirs[d] !== want_dirs[d]) begin
                        report_mismatch($sformatf("node %0d %s: got %h, expected %h",
                                        results_seen, dir_label(d), got_dirs[d],
                                        want_dirs[d]));
                    end
                end
                results_seen++;
            end
        end
    end

    // The run is stuck if no channel completes a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
